>>> sv/perspective_project_to_screen_macros.svh
// assertion macros shared by the projection block
`ifndef PERSPECTIVE_PROJECT_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_PROJECT_TO_SCREEN_MACROS_SVH
`ifndef SYNTHESIS
`define PPTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ppts check failed");
`define PPTS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ppts check failed");
`else
`define PPTS_ASSERT(lbl, prop)
`define PPTS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/ppts_pkg.sv
package ppts_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    // quotient bits kept by the divider; larger quotients saturate anyway
    localparam int QBITS  = 34;
    localparam int NBITS  = 61;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // register indexes
    localparam logic [2:0] REG_R0_01 = 3'd0;
    localparam logic [2:0] REG_R0_23 = 3'd1;
    localparam logic [2:0] REG_R1_01 = 3'd2;
    localparam logic [2:0] REG_R1_23 = 3'd3;
    localparam logic [2:0] REG_R3_01 = 3'd4;
    localparam logic [2:0] REG_R3_23 = 3'd5;
    localparam logic [2:0] REG_WIDTH = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    typedef struct packed {
        logic signed [31:0] m00, m01, m02, m03;
        logic signed [31:0] m10, m11, m12, m13;
        logic signed [31:0] m30, m31, m32, m33;
        logic [13:0]        scr_w;
        logic [13:0]        scr_h;
    } t_cfg;

    // classified item between front and back
    typedef struct packed {
        logic signed [45:0] nx;
        logic signed [45:0] ny;
        logic signed [31:0] w;
        logic               cxneg;
        logic               cyneg;
    } t_mid;

    // one divider stage
    typedef struct packed {
        logic [32:0]       remx;
        logic [32:0]       remy;
        logic [QBITS-1:0]  nlox;
        logic [QBITS-1:0]  nloy;
        logic [QBITS-1:0]  qx;
        logic [QBITS-1:0]  qy;
        logic [31:0]       d;
        logic signed [31:0] w;
        logic              negx, negy, ovfx, ovfy, cxneg, cyneg;
    } t_div;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] w;
        logic               wz;
    } t_res;

endpackage

>>> sv/ppts_queue.sv
`include "perspective_project_to_screen_macros.svh"
module ppts_queue import ppts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    output logic o_full,
    input  logic i_pop,
    output t_mid o_data,
    output logic o_empty
);

    t_mid             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCW'(do_push) - QCW'(do_pop);
        end
    end

    `PPTS_ASSERT(a_q_cnt_max, r_cnt <= QCW'(QDEPTH))

endmodule

>>> sv/ppts_front.sv
`include "perspective_project_to_screen_macros.svh"
module ppts_front import ppts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  t_cfg               i_cfg,
    output logic               o_mid_push,
    output t_mid               o_mid_data,
    input  logic               i_mid_full
);

    logic               r_v1, r_v2, r_v3;
    logic signed [63:0] r_p [9];
    logic signed [31:0] r_m03, r_m13, r_m33;
    logic signed [31:0] r_cx, r_cy, r_w;
    t_mid               r_mid;
    logic               stall;

    // round to q16.16 with halves up, then saturate
    function automatic logic signed [31:0] row_sum(input logic signed [63:0] pa,
                                                   input logic signed [63:0] pb,
                                                   input logic signed [63:0] pc,
                                                   input logic signed [31:0] m3);
        logic signed [65:0] s;
        logic signed [49:0] t;
        s = 66'(pa) + 66'(pb) + 66'(pc) + (66'(m3) <<< 16) + 66'sh8000;
        t = s[65:16];
        if (t > 50'sd2147483647)       row_sum = SAT_MAX;
        else if (t < -50'sd2147483648) row_sum = SAT_MIN;
        else                           row_sum = t[31:0];
    endfunction

    assign stall      = r_v3 && i_mid_full;
    assign o_full     = stall;
    assign o_mid_push = r_v3;
    assign o_mid_data = r_mid;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (!stall) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // products, dot products, numerators
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_p[0] <= i_cfg.m00 * i_pos_x;
            r_p[1] <= i_cfg.m01 * i_pos_y;
            r_p[2] <= i_cfg.m02 * i_pos_z;
            r_p[3] <= i_cfg.m10 * i_pos_x;
            r_p[4] <= i_cfg.m11 * i_pos_y;
            r_p[5] <= i_cfg.m12 * i_pos_z;
            r_p[6] <= i_cfg.m30 * i_pos_x;
            r_p[7] <= i_cfg.m31 * i_pos_y;
            r_p[8] <= i_cfg.m32 * i_pos_z;
            r_m03  <= i_cfg.m03;
            r_m13  <= i_cfg.m13;
            r_m33  <= i_cfg.m33;

            r_cx <= row_sum(r_p[0], r_p[1], r_p[2], r_m03);
            r_cy <= row_sum(r_p[3], r_p[4], r_p[5], r_m13);
            r_w  <= row_sum(r_p[6], r_p[7], r_p[8], r_m33);

            r_mid.nx    <= 46'(r_cx * $signed({1'b0, i_cfg.scr_w}));
            r_mid.ny    <= 46'(r_cy * $signed({1'b0, i_cfg.scr_h}));
            r_mid.w     <= r_w;
            r_mid.cxneg <= r_cx[31];
            r_mid.cyneg <= r_cy[31];
        end
    end

    `PPTS_ASSERT(a_front_hold, stall |=> r_v3)

endmodule

>>> sv/ppts_back.sv
`include "perspective_project_to_screen_macros.svh"
module ppts_back import ppts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [13:0] i_scr_w,
    input  logic [13:0] i_scr_h,
    input  t_mid        i_mid_data,
    input  logic        i_mid_empty,
    output logic        o_mid_pop,
    output t_res        o_res,
    output logic        o_empty,
    input  logic        i_pop
);

    t_div             r_st [QBITS+1];
    logic [QBITS:0]   r_dv;
    t_res             r_f;
    logic             r_fv;
    t_res             r_oq [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             oq_full, stall, oq_push, oq_pop;

    logic [45:0]       ax, ay;
    logic [31:0]       ad;
    logic [NBITS-1:0]  bigx, bigy;
    t_div              st0;
    t_res              fin;

    function automatic t_div div_step(input t_div s);
        t_div  o;
        logic [32:0] tx, ty;
        o  = s;
        tx = {s.remx[31:0], s.nlox[QBITS-1]};
        ty = {s.remy[31:0], s.nloy[QBITS-1]};
        o.nlox = s.nlox << 1;
        o.nloy = s.nloy << 1;
        if (tx >= {1'b0, s.d}) begin
            o.remx = tx - {1'b0, s.d};
            o.qx   = {s.qx[QBITS-2:0], 1'b1};
        end else begin
            o.remx = tx;
            o.qx   = {s.qx[QBITS-2:0], 1'b0};
        end
        if (ty >= {1'b0, s.d}) begin
            o.remy = ty - {1'b0, s.d};
            o.qy   = {s.qy[QBITS-2:0], 1'b1};
        end else begin
            o.remy = ty;
            o.qy   = {s.qy[QBITS-2:0], 1'b0};
        end
        return o;
    endfunction

    // offset plus signed rounded quotient, saturated
    function automatic logic signed [31:0] place(input logic signed [36:0] off,
                                                 input logic [QBITS-1:0] q,
                                                 input logic ovf,
                                                 input logic neg);
        logic signed [36:0] qs, v;
        qs = ovf ? (37'sd1 <<< QBITS) : $signed({3'b0, q});
        v  = neg ? off - qs : off + qs;
        if (v > 37'sd2147483647)       place = SAT_MAX;
        else if (v < -37'sd2147483648) place = SAT_MIN;
        else                           place = v[31:0];
    endfunction

    assign oq_full   = (r_cnt == QCW'(QDEPTH));
    assign stall     = r_fv && oq_full;
    assign oq_push   = r_fv && !oq_full;
    assign oq_pop    = i_pop && !o_empty;
    assign o_empty   = (r_cnt == '0);
    assign o_res     = r_oq[r_rd];
    assign o_mid_pop = !i_mid_empty && !stall;

    // divider setup: magnitudes, rounding bias, overflow check
    always_comb begin
        ax   = i_mid_data.nx[45] ? 46'(-i_mid_data.nx) : 46'(i_mid_data.nx);
        ay   = i_mid_data.ny[45] ? 46'(-i_mid_data.ny) : 46'(i_mid_data.ny);
        ad   = i_mid_data.w[31]  ? 32'(-i_mid_data.w)  : 32'(i_mid_data.w);
        bigx = {ax[45:0], 15'b0} + NBITS'(ad >> 1);
        bigy = {ay[45:0], 15'b0} + NBITS'(ad >> 1);
        st0.remx  = {6'b0, bigx[NBITS-1:QBITS]};
        st0.remy  = {6'b0, bigy[NBITS-1:QBITS]};
        st0.nlox  = bigx[QBITS-1:0];
        st0.nloy  = bigy[QBITS-1:0];
        st0.qx    = '0;
        st0.qy    = '0;
        st0.d     = ad;
        st0.w     = i_mid_data.w;
        st0.negx  = i_mid_data.nx[45] ^ i_mid_data.w[31];
        st0.negy  = i_mid_data.ny[45] ^ i_mid_data.w[31];
        st0.ovfx  = {5'b0, bigx[NBITS-1:QBITS]} >= ad;
        st0.ovfy  = {5'b0, bigy[NBITS-1:QBITS]} >= ad;
        st0.cxneg = i_mid_data.cxneg;
        st0.cyneg = i_mid_data.cyneg;
    end

    // final placement on screen
    always_comb begin
        fin.w  = r_st[QBITS].w;
        fin.wz = (r_st[QBITS].w == '0);
        if (fin.wz) begin
            fin.sx = r_st[QBITS].cxneg ? SAT_MIN : SAT_MAX;
            fin.sy = r_st[QBITS].cyneg ? SAT_MAX : SAT_MIN;
        end else begin
            fin.sx = place(($signed({23'b0, i_scr_w}) + 37'sd1) <<< 15,
                           r_st[QBITS].qx, r_st[QBITS].ovfx, r_st[QBITS].negx);
            fin.sy = place(($signed({23'b0, i_scr_h}) - 37'sd1) <<< 15,
                           r_st[QBITS].qy, r_st[QBITS].ovfy, !r_st[QBITS].negy);
        end
    end

    // divider pipeline and final stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_fv <= 1'b0;
        end else if (!stall) begin
            r_dv <= {r_dv[QBITS-1:0], o_mid_pop};
            r_fv <= r_dv[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_st[0] <= st0;
            for (int k = 0; k < QBITS; k++) begin
                r_st[k+1] <= div_step(r_st[k]);
            end
            r_f <= fin;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_wr] <= r_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (oq_push) r_wr <= r_wr + 1'b1;
            if (oq_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCW'(oq_push) - QCW'(oq_pop);
        end
    end

    `PPTS_ASSERT(a_pop_enters, o_mid_pop |=> r_dv[0])
    `PPTS_ASSERT(a_wz_sat, r_fv && r_f.wz |-> (r_f.sx == SAT_MAX || r_f.sx == SAT_MIN))

endmodule

>>> sv/perspective_project_to_screen.sv
// path: a pushed point passes 3 front stages and the middle queue write, then
// 35 divider stages, 1 final stage and the result queue write before empty falls
// throughput: one point per cycle while no full queue stalls the path, set by
// the one-bit-per-stage divider pipeline
// reset: synchronous, active low; clears all queues and pipeline valids
// and loads the default view matrix and a 1920 x 1080 viewport
module perspective_project_to_screen import ppts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    output logic signed [31:0] o_depth_w,
    output logic               o_w_zero,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [63:0]        i_cfg_wdata
);

    logic [63:0] r_r0_01, r_r0_23, r_r1_01, r_r1_23, r_r3_01, r_r3_23;
    logic [13:0] r_scr_w, r_scr_h;
    t_cfg        cfg;
    t_mid        mid_in, mid_out;
    logic        mid_push, mid_full, mid_pop, mid_empty;
    t_res        res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0_01 <= 64'd65536;
            r_r0_23 <= '0;
            r_r1_01 <= 64'd65536 << 32;
            r_r1_23 <= '0;
            r_r3_01 <= '0;
            r_r3_23 <= 64'd65536 << 32;
            r_scr_w <= 14'd1920;
            r_scr_h <= 14'd1080;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_R0_01:  r_r0_01 <= i_cfg_wdata;
                REG_R0_23:  r_r0_23 <= i_cfg_wdata;
                REG_R1_01:  r_r1_01 <= i_cfg_wdata;
                REG_R1_23:  r_r1_23 <= i_cfg_wdata;
                REG_R3_01:  r_r3_01 <= i_cfg_wdata;
                REG_R3_23:  r_r3_23 <= i_cfg_wdata;
                REG_WIDTH:  r_scr_w <= i_cfg_wdata[13:0];
                REG_HEIGHT: r_scr_h <= i_cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    // unpack matrix entries
    always_comb begin
        cfg.m00   = r_r0_01[31:0];
        cfg.m01   = r_r0_01[63:32];
        cfg.m02   = r_r0_23[31:0];
        cfg.m03   = r_r0_23[63:32];
        cfg.m10   = r_r1_01[31:0];
        cfg.m11   = r_r1_01[63:32];
        cfg.m12   = r_r1_23[31:0];
        cfg.m13   = r_r1_23[63:32];
        cfg.m30   = r_r3_01[31:0];
        cfg.m31   = r_r3_01[63:32];
        cfg.m32   = r_r3_23[31:0];
        cfg.m33   = r_r3_23[63:32];
        cfg.scr_w = r_scr_w;
        cfg.scr_h = r_scr_h;
    end

    ppts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_cfg      (cfg),
        .o_mid_push (mid_push),
        .o_mid_data (mid_in),
        .i_mid_full (mid_full)
    );

    ppts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    ppts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scr_w     (r_scr_w),
        .i_scr_h     (r_scr_h),
        .i_mid_data  (mid_out),
        .i_mid_empty (mid_empty),
        .o_mid_pop   (mid_pop),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_screen_x = res.sx;
    assign o_screen_y = res.sy;
    assign o_depth_w  = res.w;
    assign o_w_zero   = res.wz;

endmodule
